/* rtl/core/zcdp_pkg.sv */
package zcdp_pkg;

    localparam logic [31:0] RECORD_SIG   = 32'h0201_4b50;
    localparam int          HEADER_BYTES = 46;
    localparam logic [7:0]  SLASH_CHAR   = 8'h2f;

    // byte offsets of the fixed header fields
    localparam logic [5:0] OFF_FLAGS    = 6'd8;
    localparam logic [5:0] OFF_METHOD   = 6'd10;
    localparam logic [5:0] OFF_TIME     = 6'd12;
    localparam logic [5:0] OFF_DATE     = 6'd14;
    localparam logic [5:0] OFF_CRC      = 6'd16;
    localparam logic [5:0] OFF_PACKED   = 6'd20;
    localparam logic [5:0] OFF_PLAIN    = 6'd24;
    localparam logic [5:0] OFF_NAMELEN  = 6'd28;
    localparam logic [5:0] OFF_EXTRALEN = 6'd30;
    localparam logic [5:0] OFF_COMMLEN  = 6'd32;
    localparam logic [5:0] OFF_LOCAL    = 6'd42;
    localparam logic [5:0] POS_SIG_END  = 6'd3;
    localparam logic [5:0] POS_LAST     = 6'(HEADER_BYTES - 1);

    typedef struct packed {
        logic [15:0] method;
        logic [15:0] mod_time;
        logic [15:0] mod_date;
        logic [31:0] checksum;
        logic [31:0] packed_size;
        logic [31:0] plain_size;
        logic [15:0] bit_flags;
        logic [31:0] local_offset;
        logic [15:0] name_length;
        logic        is_dir;
        logic        status;
        logic        last_entry;
    } t_result;

endpackage

/* rtl/core/zip_central_directory_parser.sv */
// ZIP central directory parser.
// Input channel (i_in_valid / o_in_ready): one byte of the central directory per
// beat; i_stream_start marks the first byte of a new directory and restarts the
// parser on that byte. Output channel (o_out_valid / i_out_ready): one beat per
// record with the decoded header fields, or one error beat (status 1, last 1)
// on a bad header signature, after which bytes are dropped until the next
// stream start. Config channel (i_cfg_valid / o_cfg_ready): writes entry_count,
// always ready; write it only while the block is idle.
// Throughput: one byte per cycle while o_in_ready is high; each byte passes
// through a single layer of counter and field-register logic into the result
// register. A record's result beat is registered as its last byte is accepted.
// A two-deep output buffer (result register plus skid) keeps o_in_ready high
// while one result waits; o_in_ready drops only when both hold a result, i.e.
// when the receiver stalls across two records.
// Reset: parser halted, entry_count 0, output buffer empty; bytes without
// stream_start are ignored until a stream start arrives.
module zip_central_directory_parser
    import zcdp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_stream_start,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [15:0] o_method,
    output logic [15:0] o_mod_time,
    output logic [15:0] o_mod_date,
    output logic [31:0] o_checksum,
    output logic [31:0] o_packed_size,
    output logic [31:0] o_plain_size,
    output logic [15:0] o_bit_flags,
    output logic [31:0] o_local_offset,
    output logic [15:0] o_name_length,
    output logic        o_is_dir,
    output logic        o_status,
    output logic        o_last_entry
);

    typedef enum logic [1:0] {
        PH_HALTED = 2'd0,
        PH_HEADER = 2'd1,
        PH_NAME   = 2'd2,
        PH_SKIP   = 2'd3
    } t_phase;

    t_phase      r_phase, n_phase;
    logic [5:0]  r_pos, n_pos;
    logic [23:0] r_sig, n_sig;
    logic [16:0] r_skip, n_skip;
    logic [7:0]  r_name_last, n_name_last;
    logic [15:0] r_done, n_done;
    logic [15:0] r_entry_count;

    logic [15:0] r_flags, n_flags, r_method, n_method, r_time, n_time, r_date, n_date;
    logic [31:0] r_crc, n_crc, r_packed, n_packed, r_plain, n_plain, r_local, n_local;
    logic [15:0] r_namelen, n_namelen, r_extralen, n_extralen, r_commlen, n_commlen;

    t_result r_out, r_skid, res;
    logic    r_out_valid, r_skid_valid;
    logic    accept_in, out_take, emit;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = !r_skid_valid;
    assign accept_in   = i_in_valid && o_in_ready;
    assign out_take    = r_out_valid && i_out_ready;

    always_comb begin
        t_phase      e_phase;
        logic [5:0]  e_pos;
        logic [16:0] e_skip;
        logic [16:0] dec_skip;
        logic [16:0] tail_len;
        logic [7:0]  e_name_last;
        logic [15:0] e_done;
        logic        go_tail;
        logic        go_emit;
        logic        is_last;
        logic [7:0]  b;

        b = i_data_byte;
        // stream start restarts the parser on this very byte
        if (i_stream_start) begin
            e_phase     = (r_entry_count == '0) ? PH_HALTED : PH_HEADER;
            e_pos       = '0;
            e_skip      = '0;
            e_name_last = '0;
            e_done      = '0;
        end else begin
            e_phase     = r_phase;
            e_pos       = r_pos;
            e_skip      = r_skip;
            e_name_last = r_name_last;
            e_done      = r_done;
        end

        n_phase     = e_phase;
        n_pos       = e_pos;
        n_sig       = r_sig;
        n_skip      = e_skip;
        n_name_last = e_name_last;
        n_done      = e_done;
        n_flags     = r_flags;
        n_method    = r_method;
        n_time      = r_time;
        n_date      = r_date;
        n_crc       = r_crc;
        n_packed    = r_packed;
        n_plain     = r_plain;
        n_local     = r_local;
        n_namelen   = r_namelen;
        n_extralen  = r_extralen;
        n_commlen   = r_commlen;

        go_tail  = 1'b0;
        go_emit  = 1'b0;
        emit     = 1'b0;
        res      = '0;
        dec_skip = (e_skip != '0) ? e_skip - 17'd1 : e_skip;

        if (e_phase == PH_HEADER) begin
            n_sig = {b, r_sig[23:8]};
            case (e_pos)
                OFF_FLAGS:           n_flags[7:0]     = b;
                OFF_FLAGS + 6'd1:    n_flags[15:8]    = b;
                OFF_METHOD:          n_method[7:0]    = b;
                OFF_METHOD + 6'd1:   n_method[15:8]   = b;
                OFF_TIME:            n_time[7:0]      = b;
                OFF_TIME + 6'd1:     n_time[15:8]     = b;
                OFF_DATE:            n_date[7:0]      = b;
                OFF_DATE + 6'd1:     n_date[15:8]     = b;
                OFF_CRC:             n_crc[7:0]       = b;
                OFF_CRC + 6'd1:      n_crc[15:8]      = b;
                OFF_CRC + 6'd2:      n_crc[23:16]     = b;
                OFF_CRC + 6'd3:      n_crc[31:24]     = b;
                OFF_PACKED:          n_packed[7:0]    = b;
                OFF_PACKED + 6'd1:   n_packed[15:8]   = b;
                OFF_PACKED + 6'd2:   n_packed[23:16]  = b;
                OFF_PACKED + 6'd3:   n_packed[31:24]  = b;
                OFF_PLAIN:           n_plain[7:0]     = b;
                OFF_PLAIN + 6'd1:    n_plain[15:8]    = b;
                OFF_PLAIN + 6'd2:    n_plain[23:16]   = b;
                OFF_PLAIN + 6'd3:    n_plain[31:24]   = b;
                OFF_NAMELEN:         n_namelen[7:0]   = b;
                OFF_NAMELEN + 6'd1:  n_namelen[15:8]  = b;
                OFF_EXTRALEN:        n_extralen[7:0]  = b;
                OFF_EXTRALEN + 6'd1: n_extralen[15:8] = b;
                OFF_COMMLEN:         n_commlen[7:0]   = b;
                OFF_COMMLEN + 6'd1:  n_commlen[15:8]  = b;
                OFF_LOCAL:           n_local[7:0]     = b;
                OFF_LOCAL + 6'd1:    n_local[15:8]    = b;
                OFF_LOCAL + 6'd2:    n_local[23:16]   = b;
                OFF_LOCAL + 6'd3:    n_local[31:24]   = b;
                default: ;
            endcase
        end

        tail_len = 17'(n_extralen) + 17'(n_commlen);

        case (e_phase)
            PH_HEADER: begin
                if (e_pos == POS_SIG_END && {b, r_sig} != RECORD_SIG) begin
                    // bad signature: error beat, halt until next stream start
                    emit           = 1'b1;
                    res.status     = 1'b1;
                    res.last_entry = 1'b1;
                    n_phase        = PH_HALTED;
                    n_pos          = '0;
                end else if (e_pos != POS_LAST) begin
                    n_pos = e_pos + 6'd1;
                end else begin
                    n_pos       = '0;
                    n_name_last = '0;
                    if (n_namelen != '0) begin
                        n_skip  = 17'(n_namelen);
                        n_phase = PH_NAME;
                    end else begin
                        go_tail = 1'b1;
                    end
                end
            end
            PH_NAME: begin
                n_name_last = b;
                n_skip      = dec_skip;
                if (dec_skip == '0) go_tail = 1'b1;
            end
            PH_SKIP: begin
                n_skip = dec_skip;
                if (dec_skip == '0) go_emit = 1'b1;
            end
            default: ;
        endcase

        if (go_tail) begin
            if (tail_len != '0) begin
                n_skip  = tail_len;
                n_phase = PH_SKIP;
            end else begin
                go_emit = 1'b1;
            end
        end

        is_last = (17'(e_done) + 17'd1) >= 17'(r_entry_count);
        if (go_emit) begin
            emit             = 1'b1;
            res.method       = n_method;
            res.mod_time     = n_time;
            res.mod_date     = n_date;
            res.checksum     = n_crc;
            res.packed_size  = n_packed;
            res.plain_size   = n_plain;
            res.bit_flags    = n_flags;
            res.local_offset = n_local;
            res.name_length  = n_namelen;
            res.is_dir       = (n_namelen != '0) && (n_name_last == SLASH_CHAR);
            res.status       = 1'b0;
            res.last_entry   = is_last;
            n_done           = e_done + 16'd1;
            n_pos            = '0;
            n_phase          = is_last ? PH_HALTED : PH_HEADER;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_HALTED;
            r_pos         <= '0;
            r_sig         <= '0;
            r_skip        <= '0;
            r_name_last   <= '0;
            r_done        <= '0;
            r_entry_count <= '0;
            r_out_valid   <= 1'b0;
            r_skid_valid  <= 1'b0;
        end else begin
            if (i_cfg_valid) r_entry_count <= i_cfg_data;
            if (accept_in) begin
                r_phase     <= n_phase;
                r_pos       <= n_pos;
                r_sig       <= n_sig;
                r_skip      <= n_skip;
                r_name_last <= n_name_last;
                r_done      <= n_done;
            end
            if (r_skid_valid) begin
                // skid full: input stalled, drain skid into the result register
                if (out_take) begin
                    r_out        <= r_skid;
                    r_skid_valid <= 1'b0;
                end
            end else if (!r_out_valid || out_take) begin
                r_out_valid <= accept_in && emit;
                if (accept_in && emit) r_out <= res;
            end else if (accept_in && emit) begin
                r_skid       <= res;
                r_skid_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept_in) begin
            r_flags    <= n_flags;
            r_method   <= n_method;
            r_time     <= n_time;
            r_date     <= n_date;
            r_crc      <= n_crc;
            r_packed   <= n_packed;
            r_plain    <= n_plain;
            r_local    <= n_local;
            r_namelen  <= n_namelen;
            r_extralen <= n_extralen;
            r_commlen  <= n_commlen;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_method       = r_out.method;
    assign o_mod_time     = r_out.mod_time;
    assign o_mod_date     = r_out.mod_date;
    assign o_checksum     = r_out.checksum;
    assign o_packed_size  = r_out.packed_size;
    assign o_plain_size   = r_out.plain_size;
    assign o_bit_flags    = r_out.bit_flags;
    assign o_local_offset = r_out.local_offset;
    assign o_name_length  = r_out.name_length;
    assign o_is_dir       = r_out.is_dir;
    assign o_status       = r_out.status;
    assign o_last_entry   = r_out.last_entry;

    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid holds a beat while result register is empty");

    a_error_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status) |-> (o_last_entry && o_name_length == '0))
        else $error("error beat not marked last or carries fields");

    a_halt_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept_in && emit && res.last_entry) |=> (r_phase == PH_HALTED))
        else $error("parser still running after last beat");

    a_skid_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_skid_valid) |-> $past(r_out_valid && !i_out_ready))
        else $error("skid filled without a receiver stall");

endmodule

/* tb/zip_central_directory_parser_tb.sv */
`timescale 1ns / 100ps

module zip_central_directory_parser_tb;
    import zcdp_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int HOLD_CYCLES    = 300;
    localparam int DRAIN_PAD      = 4;
    localparam int RANDOM_ITEMS   = 1650;
    localparam int TAIL_ITEMS     = 1400;

    typedef enum logic [1:0] {
        WALK_HALTED,
        WALK_HEADER,
        WALK_NAME,
        WALK_SKIP
    } t_walk_phase;

    typedef enum int {
        FILL_RANDOM,
        FILL_ZERO,
        FILL_ONES
    } t_fill;

    // Tracks the directory walk byte by byte and holds the records it should produce.
    class directory_scoreboard;
        logic [15:0] entry_count;
        t_walk_phase phase;
        logic [5:0]  hdr_pos;
        logic [31:0] sig_window;
        logic [7:0]  hdr [HEADER_BYTES];
        logic [17:0] bytes_left;
        logic [7:0]  name_tail;
        logic [15:0] records_done;
        t_result     pending_records [$];
        int          errors;
        int          results_seen;

        function new();
            entry_count  = '0;
            phase        = WALK_HALTED;
            hdr_pos      = '0;
            sig_window   = '0;
            bytes_left   = '0;
            name_tail    = '0;
            records_done = '0;
            errors       = 0;
            results_seen = 0;
            foreach (hdr[k]) hdr[k] = '0;
        endfunction

        function void set_count(logic [15:0] value);
            entry_count = value;
        endfunction

        function int pending();
            return pending_records.size();
        endfunction

        function logic [15:0] le16(logic [5:0] off);
            return {hdr[off + 6'd1], hdr[off]};
        endfunction

        function logic [31:0] le32(logic [5:0] off);
            return {hdr[off + 6'd3], hdr[off + 6'd2], hdr[off + 6'd1], hdr[off]};
        endfunction

        function void close_record();
            t_result rec;
            logic    last;
            last = ({1'b0, records_done} + 17'd1) >= {1'b0, entry_count};
            rec = '0;
            rec.method       = le16(OFF_METHOD);
            rec.mod_time     = le16(OFF_TIME);
            rec.mod_date     = le16(OFF_DATE);
            rec.checksum     = le32(OFF_CRC);
            rec.packed_size  = le32(OFF_PACKED);
            rec.plain_size   = le32(OFF_PLAIN);
            rec.bit_flags    = le16(OFF_FLAGS);
            rec.local_offset = le32(OFF_LOCAL);
            rec.name_length  = le16(OFF_NAMELEN);
            rec.is_dir       = (rec.name_length != 16'd0) && (name_tail == SLASH_CHAR);
            rec.last_entry   = last;
            pending_records.push_back(rec);
            records_done = records_done + 16'd1;
            hdr_pos = '0;
            phase = last ? WALK_HALTED : WALK_HEADER;
        endfunction

        function void end_of_name();
            logic [17:0] skip;
            skip = 18'(le16(OFF_EXTRALEN)) + 18'(le16(OFF_COMMLEN));
            if (skip != 18'd0) begin
                bytes_left = skip;
                phase = WALK_SKIP;
            end else begin
                close_record();
            end
        endfunction

        function void take_byte(logic [7:0] b, logic start);
            t_result bad;
            if (start) begin
                hdr_pos      = '0;
                records_done = '0;
                bytes_left   = '0;
                name_tail    = '0;
                phase = (entry_count == 16'd0) ? WALK_HALTED : WALK_HEADER;
            end
            case (phase)
                WALK_HEADER: begin
                    sig_window = {b, sig_window[31:8]};
                    hdr[hdr_pos] = b;
                    if (hdr_pos == POS_SIG_END && sig_window != RECORD_SIG) begin
                        bad = '0;
                        bad.status = 1'b1;
                        bad.last_entry = 1'b1;
                        pending_records.push_back(bad);
                        phase = WALK_HALTED;
                        hdr_pos = '0;
                    end else if (hdr_pos != POS_LAST) begin
                        hdr_pos = hdr_pos + 6'd1;
                    end else begin
                        hdr_pos = '0;
                        name_tail = '0;
                        if (le16(OFF_NAMELEN) != 16'd0) begin
                            bytes_left = 18'(le16(OFF_NAMELEN));
                            phase = WALK_NAME;
                        end else begin
                            end_of_name();
                        end
                    end
                end
                WALK_NAME: begin
                    name_tail = b;
                    if (bytes_left != 18'd0) bytes_left = bytes_left - 18'd1;
                    if (bytes_left == 18'd0) end_of_name();
                end
                WALK_SKIP: begin
                    if (bytes_left != 18'd0) bytes_left = bytes_left - 18'd1;
                    if (bytes_left == 18'd0) close_record();
                end
                default: ;
            endcase
        endfunction

        function void cmp_field(string label, logic [31:0] want, logic [31:0] got);
            if (got !== want) begin
                $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, label, want, got);
                errors++;
            end
        endfunction

        function void check_record(t_result got);
            t_result want;
            if (pending_records.size() == 0) begin
                $display("%0t: unexpected result beat, expected none, got 0x%0h", $time, got);
                errors++;
                return;
            end
            want = pending_records.pop_front();
            results_seen++;
            cmp_field("method", 32'(want.method), 32'(got.method));
            cmp_field("mod_time", 32'(want.mod_time), 32'(got.mod_time));
            cmp_field("mod_date", 32'(want.mod_date), 32'(got.mod_date));
            cmp_field("checksum", want.checksum, got.checksum);
            cmp_field("packed_size", want.packed_size, got.packed_size);
            cmp_field("plain_size", want.plain_size, got.plain_size);
            cmp_field("bit_flags", 32'(want.bit_flags), 32'(got.bit_flags));
            cmp_field("local_offset", want.local_offset, got.local_offset);
            cmp_field("name_length", 32'(want.name_length), 32'(got.name_length));
            cmp_field("is_dir", 32'(want.is_dir), 32'(got.is_dir));
            cmp_field("status", 32'(want.status), 32'(got.status));
            cmp_field("last_entry", 32'(want.last_entry), 32'(got.last_entry));
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n        = 1'b0;
    logic        i_cfg_valid    = 1'b0;
    logic        o_cfg_ready;
    logic [15:0] i_cfg_data     = '0;
    logic        i_in_valid     = 1'b0;
    logic        o_in_ready;
    logic [7:0]  i_data_byte    = '0;
    logic        i_stream_start = 1'b0;
    logic        o_out_valid;
    logic        i_out_ready    = 1'b0;
    logic [15:0] o_method;
    logic [15:0] o_mod_time;
    logic [15:0] o_mod_date;
    logic [31:0] o_checksum;
    logic [31:0] o_packed_size;
    logic [31:0] o_plain_size;
    logic [15:0] o_bit_flags;
    logic [31:0] o_local_offset;
    logic [15:0] o_name_length;
    logic        o_is_dir;
    logic        o_status;
    logic        o_last_entry;

    t_result     out_beat;
    bit          idle_on    = 1'b0;
    logic        hold_req   = 1'b0;
    int          items_sent = 0;
    int          quiet      = 0;
    logic [15:0] cur_count  = '0;

    directory_scoreboard sb = new();

    assign out_beat = {o_method, o_mod_time, o_mod_date, o_checksum, o_packed_size,
                       o_plain_size, o_bit_flags, o_local_offset, o_name_length,
                       o_is_dir, o_status, o_last_entry};

    zip_central_directory_parser u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_data_byte    (i_data_byte),
        .i_stream_start (i_stream_start),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_method       (o_method),
        .o_mod_time     (o_mod_time),
        .o_mod_date     (o_mod_date),
        .o_checksum     (o_checksum),
        .o_packed_size  (o_packed_size),
        .o_plain_size   (o_plain_size),
        .o_bit_flags    (o_bit_flags),
        .o_local_offset (o_local_offset),
        .o_name_length  (o_name_length),
        .o_is_dir       (o_is_dir),
        .o_status       (o_status),
        .o_last_entry   (o_last_entry)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Everything the scoreboard learns comes from handshakes seen at each rising clock.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) sb.set_count(i_cfg_data);
            if (o_out_valid && i_out_ready) sb.check_record(out_beat);
            if (i_in_valid && o_in_ready) sb.take_byte(i_data_byte, i_stream_start);
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
                (i_cfg_valid && o_cfg_ready)) begin
            quiet <= 0;
        end else begin
            quiet <= quiet + 1;
            if (quiet >= WATCHDOG_LIMIT) begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    // Result side: random stall bursts, plus one long hold on request.
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                i_out_ready <= 1'b1;
                hold_req <= 1'b0;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                i_out_ready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge i_clk);
                i_out_ready <= 1'b1;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic start);
        if (idle_on && $urandom_range(0, 7) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_data_byte    <= b;
        i_stream_start <= start;
        do @(posedge i_clk); while (!o_in_ready);
        items_sent++;
    endtask

    task automatic send_noise(input int count);
        for (int k = 0; k < count; k++) send_byte(8'($urandom), 1'b0);
    endtask

    // Drop valid and wait out every expected record before touching the count.
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_PAD) @(posedge i_clk);
    endtask

    task automatic write_count(input logic [15:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        cur_count = value;
    endtask

    // One central directory record; upto > 0 cuts it short after that many bytes.
    task automatic send_record(input bit first, input int name_len, input int ext_len,
                               input int comm_len, input bit dir_name, input bit bad_sig,
                               input t_fill fill, input int upto);
        logic [7:0] hdr [HEADER_BYTES];
        int         total;
        int         name_end;
        logic [7:0] b;
        for (int k = 0; k < HEADER_BYTES; k++) hdr[k] = 8'($urandom);
        if (fill != FILL_RANDOM) begin
            for (int k = 0; k < HEADER_BYTES; k++) begin
                if ((k >= 8 && k < 28) || k >= 42) hdr[k] = (fill == FILL_ONES) ? 8'hff : 8'h00;
            end
        end
        {hdr[3], hdr[2], hdr[1], hdr[0]} = RECORD_SIG;
        if (bad_sig) hdr[$urandom_range(0, 3)] ^= 8'(1 << $urandom_range(0, 7));
        {hdr[OFF_NAMELEN + 6'd1], hdr[OFF_NAMELEN]}   = 16'(name_len);
        {hdr[OFF_EXTRALEN + 6'd1], hdr[OFF_EXTRALEN]} = 16'(ext_len);
        {hdr[OFF_COMMLEN + 6'd1], hdr[OFF_COMMLEN]}   = 16'(comm_len);
        name_end = HEADER_BYTES + name_len;
        total = name_end + ext_len + comm_len;
        // after a bad signature the block drops bytes; send a few anyway
        if (bad_sig) total = 4 + $urandom_range(0, 3);
        if (upto > 0 && upto < total) total = upto;
        for (int pos = 0; pos < total; pos++) begin
            if (pos < HEADER_BYTES) begin
                b = hdr[pos];
            end else begin
                b = 8'($urandom);
                if (pos == name_end - 1) begin
                    if (dir_name) b = SLASH_CHAR;
                    else if (b == SLASH_CHAR) b = 8'h2e;
                end
            end
            send_byte(b, first && pos == 0);
        end
    endtask

    function automatic int pick_len();
        int r;
        r = $urandom_range(0, 19);
        if (r < 6) return 0;
        if (r < 12) return $urandom_range(1, 3);
        if (r < 18) return $urandom_range(4, 12);
        return $urandom_range(13, 80);
    endfunction

    function automatic logic [15:0] pick_count();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0) return 16'd0;
        if (r == 1) return 16'hffff;
        if (r == 2) return 16'd1;
        return 16'($urandom_range(1, 6));
    endfunction

    function automatic t_fill pick_fill();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0) return FILL_ZERO;
        if (r == 1) return FILL_ONES;
        return FILL_RANDOM;
    endfunction

    initial begin
        int  n;
        int  cut;
        bit  bad;
        bit  hold_done;
        bit  tail_part;

        hold_done = 1'b0;
        tail_part = 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // halted out of reset: bytes without a stream start are dropped
        idle_on = 1'b1;
        send_noise(3);

        // stream start with no entries expected
        wait_drained();
        write_count(16'd0);
        send_byte(8'h50, 1'b1);
        send_noise(5);

        // records ending on header byte 45, on the last name byte, on the last skip byte
        wait_drained();
        write_count(16'd3);
        send_record(1'b1, 0, 0, 0, 1'b1, 1'b0, FILL_ZERO, 0);
        send_record(1'b0, 5, 0, 0, 1'b1, 1'b0, FILL_RANDOM, 0);
        send_record(1'b0, 3, 2, 1, 1'b0, 1'b0, FILL_ONES, 0);
        send_noise(2);

        // bad signature in a later record, then in the first one
        wait_drained();
        write_count(16'hffff);
        send_record(1'b1, 2, 1, 1, 1'b1, 1'b0, FILL_RANDOM, 0);
        send_record(1'b0, 0, 0, 0, 1'b0, 1'b1, FILL_RANDOM, 0);
        send_noise(3);
        send_record(1'b1, 0, 0, 0, 1'b0, 1'b1, FILL_RANDOM, 0);

        // restart in the middle of a name
        send_record(1'b1, 20, 0, 0, 1'b0, 1'b0, FILL_RANDOM, 55);
        send_record(1'b1, 1, 0, 0, 1'b1, 1'b0, FILL_RANDOM, 0);
        send_record(1'b0, 0, 4, 0, 1'b1, 1'b0, FILL_RANDOM, 0);

        // lower the count below the records already reported
        wait_drained();
        write_count(16'd5);
        for (int k = 0; k < 3; k++) send_record(k == 0, pick_len(), pick_len(), pick_len(),
                                                1'($urandom), 1'b0, FILL_RANDOM, 0);
        wait_drained();
        write_count(16'd2);
        send_record(1'b0, 2, 0, 3, 1'b0, 1'b0, FILL_RANDOM, 0);
        send_noise(2);

        // longest name, then a skip count past 16 bits; both cut short, so no result
        wait_drained();
        write_count(16'd1);
        idle_on = 1'b0;
        send_record(1'b1, 65535, 65535, 65535, 1'b1, 1'b0, FILL_ONES, 120);
        send_record(1'b1, 2, 65535, 1, 1'b0, 1'b0, FILL_RANDOM, 60);

        while (items_sent < RANDOM_ITEMS) begin
            if (items_sent >= TAIL_ITEMS) tail_part = 1'b1;
            idle_on = !tail_part && ($urandom_range(0, 3) != 0);

            if (!hold_done && items_sent >= 600) begin
                // stall results long enough for the block to back up its input
                hold_done = 1'b1;
                idle_on = 1'b0;
                wait_drained();
                write_count(16'd6);
                hold_req <= 1'b1;
                for (int k = 0; k < 6; k++) send_record(k == 0, 0, 0, 0, 1'b0, 1'b0,
                                                        FILL_RANDOM, 0);
            end

            if ($urandom_range(0, 2) == 0) begin
                wait_drained();
                write_count(pick_count());
            end
            if (cur_count == 16'd0 || cur_count > 16'd8) n = $urandom_range(1, 4);
            else n = int'(cur_count) + (($urandom_range(0, 4) == 0) ? 1 : 0);

            for (int r = 0; r < n; r++) begin
                bad = ($urandom_range(0, 24) == 0);
                cut = ($urandom_range(0, 19) == 0) ? $urandom_range(1, 40) : 0;
                send_record(r == 0, pick_len(), pick_len(), pick_len(), 1'($urandom), bad,
                            pick_fill(), cut);
                if (bad || cut != 0) break;
            end

            if ($urandom_range(0, 9) == 0) begin
                for (int k = $urandom_range(1, 6); k > 0; k--) begin
                    send_byte(8'($urandom), $urandom_range(0, 15) == 0);
                end
            end
        end

        idle_on = 1'b0;
        wait_drained();
        repeat (10) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

/* sim.f */
rtl/core/zcdp_pkg.sv
rtl/core/zip_central_directory_parser.sv
tb/zip_central_directory_parser_tb.sv
